[rtl/core/quat_to_euler_defines.svh]
// Assertion macros shared by the quaternion to Euler angle RTL.
// Depends on nothing; files that assert include it by name.
`ifndef QUAT_TO_EULER_DEFINES_SVH
`define QUAT_TO_EULER_DEFINES_SVH

// Checks that a signed value stays within plus or minus a limit while a condition holds.
`define Q2E_ASSERT_RANGE(label, cond, sig, lim) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> ((sig) <= (lim) && (sig) >= -(lim))) \
        else $error("range check failed");

// Checks that one condition implies another at the same clock edge.
`define Q2E_ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

`endif

[rtl/core/q2e_pkg.sv]
// Package for the quaternion to Euler angle converter: widths, lane types
// and the CORDIC arctangent table. Depends on nothing.
package q2e_pkg;

    localparam int CW = 16;
    localparam int TW = 35;
    localparam int XW = 38;
    localparam int ZW = 26;
    localparam int RW = 58;
    localparam int SQRT_CELLS = 29;
    localparam int MAX_STAGES = 24;

    localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'sd1 <<< 28);

    localparam logic [21:0] ATAN_TAB [MAX_STAGES] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    typedef struct packed {
        logic [RW-1:0] op;
        logic [RW-1:0] res;
    } sqrt_t;

    typedef struct packed {
        logic signed [TW-1:0] t0;
        logic signed [TW-1:0] t1;
        logic signed [TW-1:0] t2;
        logic signed [TW-1:0] t3;
        logic signed [TW-1:0] t4;
    } terms_t;

endpackage

[rtl/core/q2e_sqrt_cell.sv]
// One digit step of the pipelined integer square root.
// Depends on q2e_pkg.
module q2e_sqrt_cell
    import q2e_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic  clk,
    input  logic  en,
    input  sqrt_t din,
    output sqrt_t dout
);

    localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);

    sqrt_t         data_reg;
    sqrt_t         data_next;
    logic [RW-1:0] trial;

    always_comb
    begin
        trial = din.res + BIT;
        if (din.op >= trial)
        begin
            data_next.op  = din.op - trial;
            data_next.res = (din.res >> 1) + BIT;
        end
        else
        begin
            data_next.op  = din.op;
            data_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

[rtl/core/q2e_cordic_cell.sv]
// One vectoring CORDIC iteration with a fixed shift and angle step.
// Depends on q2e_pkg.
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int I = 0
)
(
    input  logic    clk,
    input  logic    en,
    input  cordic_t din,
    output cordic_t dout
);

    localparam logic signed [ZW-1:0] STEP = ZW'(ATAN_TAB[I]);

    cordic_t              data_reg;
    cordic_t              data_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    always_comb
    begin
        xs = din.x >>> I;
        ys = din.y >>> I;
        data_next.zero = din.zero;
        if (!din.y[XW-1])
        begin
            data_next.x = din.x + ys;
            data_next.y = din.y - xs;
            data_next.z = din.z + STEP;
        end
        else
        begin
            data_next.x = din.x - ys;
            data_next.y = din.y + xs;
            data_next.z = din.z - STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

[rtl/core/q2e_atan2.sv]
// Pipelined atan2 lane: quadrant fold, a chain of CORDIC cells, rounding
// to 1/64 degree and clamping. Depends on q2e_pkg and q2e_cordic_cell.
module q2e_atan2
    import q2e_pkg::*;
#(
    parameter int NS  = 16,
    parameter int LIM = 11520
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [TW-1:0] y_in,
    input  logic signed [TW-1:0] x_in,
    output logic signed [15:0]   angle
);

    localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] LIMZ  = ZW'(LIM);

    cordic_t              chain [NS+1];
    cordic_t              pre_reg;
    cordic_t              pre_next;
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    logic signed [ZW-1:0] zr;
    logic signed [15:0]   angle_reg;
    logic signed [15:0]   angle_next;

    always_comb
    begin
        xe = XW'(x_in);
        ye = XW'(y_in);
        pre_next.zero = (x_in == '0) && (y_in == '0);
        if (!x_in[TW-1])
        begin
            pre_next.x = xe;
            pre_next.y = ye;
            pre_next.z = '0;
        end
        else if (!y_in[TW-1])
        begin
            pre_next.x = ye;
            pre_next.y = -xe;
            pre_next.z = DEG90;
        end
        else
        begin
            pre_next.x = -ye;
            pre_next.y = xe;
            pre_next.z = -DEG90;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg   <= pre_next;
            angle_reg <= angle_next;
        end
    end

    assign chain[0] = pre_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cell
        q2e_cordic_cell #(.I(i)) u_cell (
            .clk  (clk),
            .en   (en),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    always_comb
    begin
        zr = (chain[NS].z + ZW'(512)) >>> 10;
        if (chain[NS].zero)
        begin
            angle_next = '0;
        end
        else if (zr > LIMZ)
        begin
            angle_next = 16'(LIMZ);
        end
        else if (zr < -LIMZ)
        begin
            angle_next = 16'(-LIMZ);
        end
        else
        begin
            angle_next = 16'(zr);
        end
    end

    assign angle = angle_reg;

endmodule

[rtl/core/quat_to_euler.sv]
// Quaternion to roll, pitch and yaw converter, top level.
// Depends on q2e_pkg, q2e_sqrt_cell, q2e_atan2 and quat_to_euler_defines.svh.
//
// Usage: one quaternion transfer on the slave stream gives one angle transfer
// on the master stream. Input tdata holds w, x, y, z in signed fixed point
// with two integer bits; output tdata holds roll, pitch and yaw in 1/64 deg.
// A new quaternion is taken every cycle unless the receiver stalls. The cell
// chain holds four arithmetic stages, 29 square root cells, a quadrant fold,
// N CORDIC cells (N is CORDIC_STAGES capped at 24) and the rounding register.
// All stages advance together. When the receiver stalls with a result held
// in the output register, the whole pipeline holds and s_axis_tready drops;
// bubbles travel through the pipeline and are squeezed out only at the end.
// Reset clears all valid flags; no result is presented until new data
// arrives. The block keeps no state between quaternions.
`include "quat_to_euler_defines.svh"

module quat_to_euler
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES   = 16,
    parameter int COMPONENT_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from the lowest bit up, zero filled.
    input  logic [8*((4*COMPONENT_WIDTH+7)/8)-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle from the lowest bit up, zero filled.
    output logic [47:0] m_axis_tdata
);

    localparam int NS  = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    localparam int DLY = SQRT_CELLS + 2;
    localparam int LAT = 4 + SQRT_CELLS + 2 + NS;

    logic                    advance;
    logic [LAT-1:0]          valid_reg;
    logic signed [CW-1:0]    comp [4];
    logic signed [2*CW-1:0]  prod_reg [9];
    terms_t                  terms_reg;
    terms_t                  terms_next;
    terms_t                  dly_reg [DLY];
    logic [28:0]             t2_abs;
    logic [RW-1:0]           sq_reg;
    sqrt_t                   root [SQRT_CELLS+1];
    sqrt_t                   rad_reg;
    logic signed [TW-1:0]    c_val;
    logic signed [TW-1:0]    pitch_arg;
    logic signed [15:0]      roll_val;
    logic signed [15:0]      pitch_val;
    logic signed [15:0]      yaw_val;

    assign advance       = !valid_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_comp
        logic signed [COMPONENT_WIDTH-1:0] raw;
        assign raw = s_axis_tdata[c*COMPONENT_WIDTH +: COMPONENT_WIDTH];
        if (COMPONENT_WIDTH >= CW)
        begin : g_shr
            assign comp[c] = CW'(raw >>> (COMPONENT_WIDTH - CW));
        end
        else
        begin : g_shl
            assign comp[c] = CW'(raw) <<< (CW - COMPONENT_WIDTH);
        end
    end

    // comp: 0 = w, 1 = x, 2 = y, 3 = z.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg[0] <= comp[0] * comp[1];
            prod_reg[1] <= comp[2] * comp[3];
            prod_reg[2] <= comp[1] * comp[1];
            prod_reg[3] <= comp[2] * comp[2];
            prod_reg[4] <= comp[3] * comp[3];
            prod_reg[5] <= comp[0] * comp[2];
            prod_reg[6] <= comp[3] * comp[1];
            prod_reg[7] <= comp[0] * comp[3];
            prod_reg[8] <= comp[1] * comp[2];
        end
    end

    always_comb
    begin
        logic signed [TW-1:0] p2;
        p2 = (TW'(prod_reg[5]) - TW'(prod_reg[6])) <<< 1;
        terms_next.t0 = (TW'(prod_reg[0]) + TW'(prod_reg[1])) <<< 1;
        terms_next.t1 = ONE_Q28 - ((TW'(prod_reg[2]) + TW'(prod_reg[3])) <<< 1);
        terms_next.t3 = (TW'(prod_reg[7]) + TW'(prod_reg[8])) <<< 1;
        terms_next.t4 = ONE_Q28 - ((TW'(prod_reg[3]) + TW'(prod_reg[4])) <<< 1);
        if (p2 > ONE_Q28)
        begin
            terms_next.t2 = ONE_Q28;
        end
        else if (p2 < -ONE_Q28)
        begin
            terms_next.t2 = -ONE_Q28;
        end
        else
        begin
            terms_next.t2 = p2;
        end
    end

    assign t2_abs = terms_reg.t2[TW-1] ? 29'(-terms_reg.t2) : 29'(terms_reg.t2);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            terms_reg   <= terms_next;
            sq_reg      <= RW'(t2_abs) * RW'(t2_abs);
            rad_reg.op  <= (RW'(1) << 56) - sq_reg;
            rad_reg.res <= '0;
            dly_reg[0]  <= terms_reg;
            for (int i = 1; i < DLY; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign root[0] = rad_reg;

    for (genvar k = 0; k < SQRT_CELLS; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(.K(SQRT_CELLS - 1 - k)) u_cell (
            .clk  (clk),
            .en   (advance),
            .din  (root[k]),
            .dout (root[k+1])
        );
    end

    assign c_val     = TW'(root[SQRT_CELLS].res);
    assign pitch_arg = dly_reg[DLY-1].t2;

    q2e_atan2 #(.NS(NS), .LIM(11520)) u_roll (
        .clk   (clk),
        .en    (advance),
        .y_in  (dly_reg[DLY-1].t0),
        .x_in  (dly_reg[DLY-1].t1),
        .angle (roll_val)
    );

    q2e_atan2 #(.NS(NS), .LIM(5760)) u_pitch (
        .clk   (clk),
        .en    (advance),
        .y_in  (pitch_arg),
        .x_in  (c_val),
        .angle (pitch_val)
    );

    q2e_atan2 #(.NS(NS), .LIM(11520)) u_yaw (
        .clk   (clk),
        .en    (advance),
        .y_in  (dly_reg[DLY-1].t3),
        .x_in  (dly_reg[DLY-1].t4),
        .angle (yaw_val)
    );

    assign m_axis_tdata = {4'b0, yaw_val[14:0], pitch_val[13:0], roll_val[14:0]};

    `Q2E_ASSERT_RANGE(a_roll_range, m_axis_tvalid, roll_val, 16'sd11520)
    `Q2E_ASSERT_RANGE(a_pitch_range, m_axis_tvalid, pitch_val, 16'sd5760)
    `Q2E_ASSERT_RANGE(a_yaw_range, m_axis_tvalid, yaw_val, 16'sd11520)
    `Q2E_ASSERT_IMPL(a_root_bound, valid_reg[SQRT_CELLS+3], c_val <= ONE_Q28 && c_val >= 0)

endmodule

[test/quat_to_euler_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for quat_to_euler: predicts roll, pitch and yaw for each input transfer
// and compares them with each output transfer. Depends on nothing but the stream signals.
module quat_to_euler_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [47:0] m_data,
    output int          errors,
    output int          pending,
    output int          results
);

    localparam int STAGES = 16;
    localparam longint ONE = 64'sd1 <<< 28;
    localparam longint ARCTAN [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic [47:0] angles_due [$];
    int          bad;
    int          got;

    assign errors  = bad;
    assign pending = angles_due.size();
    assign results = got;

    function automatic longint limit_to(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint vector_angle(longint y, longint x, longint lim);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 90 * 65536;
            end
            else
            begin
                x = -y;
                y = t;
                z = -90 * 65536;
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN[i];
            end
        end
        return limit_to((z + 512) >>> 10, lim);
    endfunction

    function automatic longint floor_root(longint unsigned n);
        longint unsigned op;
        longint unsigned res;
        longint unsigned b;
        op = n;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (op >= res + b)
            begin
                op = op - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [47:0] euler_of(logic [63:0] q);
        longint w;
        longint x;
        longint y;
        longint z;
        longint sin_p;
        longint cos_p;
        longint roll;
        longint pitch;
        longint yaw;
        logic [47:0] r;
        w = longint'(signed'(q[15:0]));
        x = longint'(signed'(q[31:16]));
        y = longint'(signed'(q[47:32]));
        z = longint'(signed'(q[63:48]));
        sin_p = limit_to(2 * (w * y - z * x), ONE);
        cos_p = floor_root((64'd1 << 56) - longint'(sin_p * sin_p));
        roll  = vector_angle(2 * (w * x + y * z), ONE - 2 * (x * x + y * y), 11520);
        pitch = vector_angle(sin_p, cos_p, 5760);
        yaw   = vector_angle(2 * (w * z + x * y), ONE - 2 * (y * y + z * z), 11520);
        r = '0;
        r[14:0]  = roll[14:0];
        r[28:15] = pitch[13:0];
        r[43:29] = yaw[14:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [47:0] want;
        if (!rst_n)
        begin
            bad = 0;
            got = 0;
            angles_due.delete();
        end
        else
        begin
            if (s_valid && s_ready)
                angles_due.push_back(euler_of(s_data));
            if (m_valid && m_ready)
            begin
                got++;
                if (angles_due.size() == 0)
                begin
                    bad++;
                    if (bad <= 10)
                        $display("unexpected result transfer %h", m_data);
                end
                else
                begin
                    want = angles_due.pop_front();
                    if (m_data[14:0] != want[14:0] || m_data[28:15] != want[28:15]
                        || m_data[43:29] != want[43:29] || m_data[47:44] != want[47:44])
                    begin
                        bad++;
                        if (bad <= 10)
                            $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                                signed'(want[14:0]), signed'(m_data[14:0]),
                                signed'(want[28:15]), signed'(m_data[28:15]),
                                signed'(want[43:29]), signed'(m_data[43:29]));
                    end
                end
            end
        end
    end

endmodule

[test/tb_quat_to_euler.sv]
`timescale 1ns / 1ps
// Testbench top for quat_to_euler: drives quaternion transfers, stalls the output
// and gives the verdict. Depends on quat_to_euler and quat_to_euler_checker.
module tb_quat_to_euler;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    int  errors;
    int  pending;
    int  results;
    int  send_idle;
    int  recv_idle;
    int  hold_cycles;
    bit  hold_req;
    int  sent;
    longint cycles;

    quat_to_euler uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    quat_to_euler_checker scoreboard
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .s_data(s_axis_tdata),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .m_data(m_axis_tdata),
        .errors(errors),
        .pending(pending),
        .results(results)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 0;
        hold_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_cycles == 0)
                hold_cycles = 300;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready = 0;
            end
            else
                m_axis_tready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_quat(int w, int x, int y, int z);
        while ($urandom_range(0, 99) < send_idle)
        begin
            @(negedge clk);
            s_axis_tvalid = 0;
        end
        @(negedge clk);
        s_axis_tvalid = 1;
        s_axis_tdata = {16'(z), 16'(y), 16'(x), 16'(w)};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
    endtask

    task automatic send_random;
        real a;
        real b;
        real c;
        real d;
        real n;
        if ($urandom_range(0, 3) == 0)
            send_quat($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                      $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
        else
        begin
            a = real'(int'($urandom_range(0, 2000)) - 1000);
            b = real'(int'($urandom_range(0, 2000)) - 1000);
            c = real'(int'($urandom_range(0, 2000)) - 1000);
            d = real'(int'($urandom_range(0, 2000)) - 1000);
            if ($urandom_range(0, 7) == 0)
                b = 0.0;
            if ($urandom_range(0, 7) == 0)
                d = 0.0;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n == 0.0)
                send_quat(16384, 0, 0, 0);
            else
                send_quat($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                          $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
        end
    endtask

    task automatic drain;
        @(negedge clk);
        s_axis_tvalid = 0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        send_idle = 15;
        recv_idle = 56;
        hold_req = 0;
        sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, 0, 0, -16384);
        send_quat(0, 0, 0, 0);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(16384, -16384, 16384, -16384);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -8192, 8192, 8192);
        send_quat(16384, 0, 16384, -16384);
        send_quat(-16384, 16384, 0, 0);
        send_quat(0, 11585, 0, 11585);
        send_quat(1, -1, 1, -1);
        send_quat(-1, 0, 0, 0);
        send_quat(21845 - 16384, 16383, -16383, 5461);

        for (int i = 0; i < 530; i++)
            send_random();
        drain();

        send_idle = 56;
        recv_idle = 15;
        for (int i = 0; i < 530; i++)
            send_random();
        drain();

        send_idle = 0;
        recv_idle = 0;
        hold_req = 1;
        for (int i = 0; i < 540; i++)
        begin
            if (i == 5)
                hold_req = 0;
            send_random();
        end
        drain();
        repeat (100) @(posedge clk);

        $display("Converted %0d quaternions (unit, raw and edge values) into %0d angle sets,",
                 sent, results);
        $display("under sender gaps, receiver stalls, a long output hold-off and full rate.");
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/q2e_pkg.sv
rtl/core/q2e_sqrt_cell.sv
rtl/core/q2e_cordic_cell.sv
rtl/core/q2e_atan2.sv
rtl/core/quat_to_euler.sv
test/quat_to_euler_checker.sv
test/tb_quat_to_euler.sv
